// ===== rtl/core/dbqn_pkg.sv =====
// Package: shared types, constants and register indexes for the depth box quadrant block.
package dbqn_pkg;

  localparam int COORD_W        = 16;
  localparam int MIN_POINTS_W   = 20;
  localparam int CFG_DATA_W     = 20;
  localparam int CFG_INDEX_W    = 3;
  localparam int NUM_QUAD       = 4;
  localparam int COUNT_BITS_DEF = 20;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic signed [COORD_W-1:0] DEPTH_MAX = 16'sd32767;

  localparam logic signed [COORD_W-1:0] BOX_Y_LOW_RST  = 16'sd0;
  localparam logic signed [COORD_W-1:0] BOX_Y_HIGH_RST = 16'sd600;
  localparam logic signed [COORD_W-1:0] BOX_X_LOW_RST  = -16'sd500;
  localparam logic signed [COORD_W-1:0] BOX_X_HIGH_RST = 16'sd500;
  localparam logic signed [COORD_W-1:0] Y_SPLIT_RST    = 16'sd300;
  localparam logic [MIN_POINTS_W-1:0]   MIN_POINTS_RST = 20'd100;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BOX_Y_LOW  = 3'd0,
    CFG_BOX_Y_HIGH = 3'd1,
    CFG_BOX_X_LOW  = 3'd2,
    CFG_BOX_X_HIGH = 3'd3,
    CFG_Y_SPLIT    = 3'd4,
    CFG_MIN_POINTS = 3'd5
  } cfg_idx_e;

  // Quadrant order: low-left, high-left, low-right, high-right.
  typedef enum logic [1:0] {
    QUAD_LOW_LEFT   = 2'd0,
    QUAD_HIGH_LEFT  = 2'd1,
    QUAD_LOW_RIGHT  = 2'd2,
    QUAD_HIGH_RIGHT = 2'd3
  } quad_e;

  // One classified point as it travels from the front to the back.
  typedef struct packed {
    logic                      box_hit;
    logic [NUM_QUAD-1:0]       quad_hit;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } cls_t;

endpackage

// ===== rtl/core/dbqn_front.sv =====
// Front end: configuration registers, point intake and box/quadrant classification.
module dbqn_front import dbqn_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic signed [COORD_W-1:0] pos_z_i,
  input  logic                      point_valid_i,
  input  logic                      frame_last_i,
  output logic                      push_o,
  output cls_t                      push_item_o,
  input  logic                      full_i,
  output logic [MIN_POINTS_W-1:0]   min_points_o
);

  logic signed [COORD_W-1:0] box_y_low_q, box_y_high_q, box_x_low_q, box_x_high_q, y_split_q;
  logic [MIN_POINTS_W-1:0]   min_points_q;
  logic                      y_lo, y_hi, x_lt, x_rt, in_box;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_y_low_q  <= BOX_Y_LOW_RST;
      box_y_high_q <= BOX_Y_HIGH_RST;
      box_x_low_q  <= BOX_X_LOW_RST;
      box_x_high_q <= BOX_X_HIGH_RST;
      y_split_q    <= Y_SPLIT_RST;
      min_points_q <= MIN_POINTS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BOX_Y_LOW:  box_y_low_q  <= cfg_data_i[COORD_W-1:0];
        CFG_BOX_Y_HIGH: box_y_high_q <= cfg_data_i[COORD_W-1:0];
        CFG_BOX_X_LOW:  box_x_low_q  <= cfg_data_i[COORD_W-1:0];
        CFG_BOX_X_HIGH: box_x_high_q <= cfg_data_i[COORD_W-1:0];
        CFG_Y_SPLIT:    y_split_q    <= cfg_data_i[COORD_W-1:0];
        CFG_MIN_POINTS: min_points_q <= cfg_data_i[MIN_POINTS_W-1:0];
        default: ;
      endcase
    end
  end

  assign min_points_o = min_points_q;

  // Strict bounds everywhere; split lines belong to no quadrant.
  assign y_lo   = (pos_y_i > box_y_low_q) && (pos_y_i < y_split_q);
  assign y_hi   = (pos_y_i > y_split_q) && (pos_y_i < box_y_high_q);
  assign x_lt   = (pos_x_i < 0) && (pos_x_i > box_x_low_q);
  assign x_rt   = (pos_x_i > 0) && (pos_x_i < box_x_high_q);
  assign in_box = (pos_y_i > box_y_low_q) && (pos_y_i < box_y_high_q) &&
                  (pos_x_i > box_x_low_q) && (pos_x_i < box_x_high_q);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    push_item_o.box_hit                  = point_valid_i && in_box;
    push_item_o.quad_hit[QUAD_LOW_LEFT]  = point_valid_i && y_lo && x_lt;
    push_item_o.quad_hit[QUAD_HIGH_LEFT] = point_valid_i && y_hi && x_lt;
    push_item_o.quad_hit[QUAD_LOW_RIGHT] = point_valid_i && y_lo && x_rt;
    push_item_o.quad_hit[QUAD_HIGH_RIGHT] = point_valid_i && y_hi && x_rt;
    push_item_o.z                        = pos_z_i;
    push_item_o.last                     = frame_last_i;
  end

endmodule

// ===== rtl/core/dbqn_fifo.sv =====
// Short queue of classified points between the front and the back.
module dbqn_fifo import dbqn_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cls_t push_item_i,
  output logic full_o,
  output logic pop_valid_o,
  output cls_t pop_item_o,
  input  logic pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cls_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign pop_item_o  = mem_q[rd_ptr_q];
  assign do_pop      = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/dbqn_back.sv =====
// Back end: nearest-depth accumulators, saturating box count and result register.
module dbqn_back import dbqn_pkg::*; #(
  parameter int CountBits = COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      pop_valid_i,
  input  cls_t                      pop_item_i,
  output logic                      pop_o,
  input  logic [MIN_POINTS_W-1:0]   min_points_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_W-1:0] near_box_o,
  output logic signed [COORD_W-1:0] near_low_left_x_o,
  output logic signed [COORD_W-1:0] near_high_left_x_o,
  output logic signed [COORD_W-1:0] near_low_right_x_o,
  output logic signed [COORD_W-1:0] near_high_right_x_o
);

  localparam int CmpW = (CountBits > MIN_POINTS_W) ? CountBits : MIN_POINTS_W;

  logic signed [COORD_W-1:0] box_min_q, box_min_d;
  logic signed [COORD_W-1:0] quad_min_q [NUM_QUAD];
  logic signed [COORD_W-1:0] quad_min_d [NUM_QUAD];
  logic signed [COORD_W-1:0] quad_res   [NUM_QUAD];
  logic [NUM_QUAD-1:0]       quad_hit_q, quad_hit_d;
  logic [CountBits-1:0]      count_q, count_d;
  logic                      out_valid_q;
  logic                      take, emit;

  // Accept from the queue whenever the result slot is free or draining.
  assign pop_o = !out_valid_q || out_ready_i;
  assign take  = pop_o && pop_valid_i;

  always_comb begin
    box_min_d = box_min_q;
    count_d   = count_q;
    if (pop_item_i.box_hit) begin
      if (pop_item_i.z < box_min_q) begin
        box_min_d = pop_item_i.z;
      end
      if (!(&count_q)) begin
        count_d = count_q + 1'b1;
      end
    end
    quad_hit_d = quad_hit_q | pop_item_i.quad_hit;
    for (int i = 0; i < NUM_QUAD; i++) begin
      quad_min_d[i] = quad_min_q[i];
      if (pop_item_i.quad_hit[i] && (pop_item_i.z < quad_min_q[i])) begin
        quad_min_d[i] = pop_item_i.z;
      end
      quad_res[i] = quad_hit_d[i] ? quad_min_d[i] : '0;
    end
  end

  assign emit = take && pop_item_i.last && (CmpW'(count_d) > CmpW'(min_points_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_min_q   <= DEPTH_MAX;
      quad_hit_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_QUAD; i++) begin
        quad_min_q[i] <= DEPTH_MAX;
      end
    end else begin
      if (take) begin
        if (pop_item_i.last) begin
          box_min_q  <= DEPTH_MAX;
          quad_hit_q <= '0;
          count_q    <= '0;
          for (int i = 0; i < NUM_QUAD; i++) begin
            quad_min_q[i] <= DEPTH_MAX;
          end
        end else begin
          box_min_q  <= box_min_d;
          quad_hit_q <= quad_hit_d;
          count_q    <= count_d;
          for (int i = 0; i < NUM_QUAD; i++) begin
            quad_min_q[i] <= quad_min_d[i];
          end
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      near_box_o          <= box_min_d;
      near_low_left_x_o   <= quad_res[QUAD_LOW_LEFT];
      near_high_left_x_o  <= quad_res[QUAD_HIGH_LEFT];
      near_low_right_x_o  <= quad_res[QUAD_LOW_RIGHT];
      near_high_right_x_o <= quad_res[QUAD_HIGH_RIGHT];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/depth_box_quadrant_nearest.sv =====
// Top level: nearest depth inside a box and its four quadrants, one result per frame
// whose box count exceeds min_points. Throughput: one point per cycle while the queue
// has room; the back end folds a point into the minima each cycle its result slot is
// free or draining. A frame's last point passes the queue, then the result register.
// Reset: config registers return to their defaults, minima to 32767, count and hits to 0,
// and the queue and result register empty. No clearing pass; points are taken right away.
module depth_box_quadrant_nearest import dbqn_pkg::*; #(
  parameter int CountBits  = COUNT_BITS_DEF,
  parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic signed [COORD_W-1:0] pos_z_i,
  input  logic                      point_valid_i,
  input  logic                      frame_last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_W-1:0] near_box_o,
  output logic signed [COORD_W-1:0] near_low_left_x_o,
  output logic signed [COORD_W-1:0] near_high_left_x_o,
  output logic signed [COORD_W-1:0] near_low_right_x_o,
  output logic signed [COORD_W-1:0] near_high_right_x_o
);

  logic                    push, full, pop_valid, pop;
  cls_t                    push_item, pop_item;
  logic [MIN_POINTS_W-1:0] min_points;

  // Front: hold the config, classify each request against box and quadrants.
  dbqn_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .point_valid_i (point_valid_i),
    .frame_last_i  (frame_last_i),
    .push_o        (push),
    .push_item_o   (push_item),
    .full_i        (full),
    .min_points_o  (min_points)
  );

  // Queue: absorb points while the result register waits on the consumer.
  dbqn_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_item_o  (pop_item),
    .pop_i       (pop)
  );

  // Back: fold minima and count; at frame end emit if count > min_points, then clear.
  dbqn_back #(
    .CountBits (CountBits)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .pop_valid_i         (pop_valid),
    .pop_item_i          (pop_item),
    .pop_o               (pop),
    .min_points_i        (min_points),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .near_box_o          (near_box_o),
    .near_low_left_x_o   (near_low_left_x_o),
    .near_high_left_x_o  (near_high_left_x_o),
    .near_low_right_x_o  (near_low_right_x_o),
    .near_high_right_x_o (near_high_right_x_o)
  );

endmodule
